// ===== rtl/core/motion_group_integrator_assert.svh =====
// assertion macros shared by the motion group integrator rtl
`ifndef MOTION_GROUP_INTEGRATOR_ASSERT_SVH
`define MOTION_GROUP_INTEGRATOR_ASSERT_SVH

`ifndef SYNTHESIS

// implication or plain property, checked at every rising edge out of reset
`define MGI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("motion group integrator assertion failed");

// condition that must never be seen out of reset
`define MGI_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("motion group integrator forbidden condition");

`else

`define MGI_ASSERT(lbl, clk, rst_n, prop)
`define MGI_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/core/mgi_pkg.sv =====
// types, constants and helpers of the motion group integrator
`default_nettype none

package mgi_pkg;

  localparam int unsigned MaxEntriesDefault = 64;
  localparam int unsigned WordW             = 32;

  localparam logic [WordW-1:0] ScaleOne         = 32'h0000_0100;
  localparam logic [15:0]      RestitutionReset = 16'h0080;
  localparam logic [6:0]       EntriesReset     = 7'd1;

  // configuration register indexes
  localparam logic [1:0] RegEntries     = 2'd0;
  localparam logic [1:0] RegBoundary    = 2'd1;
  localparam logic [1:0] RegRestitution = 2'd2;
  localparam logic [1:0] RegAxisMode    = 2'd3;

  typedef enum logic [1:0] {
    OpTick    = 2'd0,
    OpLoad    = 2'd1,
    OpRampAcc = 2'd2,
    OpRampVel = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e            opcode;
    logic [5:0]         entry_index;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic signed [31:0] first_step;
    logic signed [31:0] second_step;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         out_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               last;
  } out_item_t;

  // arithmetic shift right by 8 of a wrapped 32-bit word
  function automatic logic [WordW-1:0] asr8(input logic [WordW-1:0] v);
    return {{8{v[WordW-1]}}, v[WordW-1:8]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/motion_group_integrator.sv =====
// motion group integrator top level: sequencer, stores and config port
//
// Table of up to MAX_ENTRIES moving points, each with x/y position,
// velocity and acceleration held in three two-port rams ({y, x} per
// word). Opcode 0 (tick) steps entries 0..n-1, where n is entries_in_use
// saturated to MAX_ENTRIES: position += velocity, velocity += acceleration,
// one output transaction per entry carrying the position before any
// boundary snap, last set on the final entry. When axis_mode[1:0] is
// nonzero the axis picked by axis_mode[0] (1 = x, 0 = y) is checked, and
// an entry whose position and predicted next position straddle the
// boundary snaps to it with that velocity zeroed, or with bounce
// (axis_mode[2]) set to -(restitution * v) >> 8. Opcode 1 loads one
// position and clears its motion; opcodes 2 and 3 ramp accelerations or
// velocities with a scale of 0x100 growing by the step per entry.
// Timing: the block takes one input transaction at a time and drops
// in_ready_o until that transaction is done. A ramp uses the single
// shared multiplier for the x and then the y product of each entry. A
// tick steps each entry through read, add, check and emit, and write back;
// a stalled output holds the tick in emit until the output register, which
// holds one result, is free, so the consumer may take a result while the
// next entry is being read. A table entry that was never loaded or ramped
// reads as garbage. Configuration goes through an APB-style port,
// registers at byte addresses 0, 4, 8 and 12, to be written only while the
// block is idle; the block itself does not enforce this.
`default_nettype none

`include "motion_group_integrator_assert.svh"

module motion_group_integrator #(
  parameter int unsigned MAX_ENTRIES = mgi_pkg::MaxEntriesDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input transactions
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire mgi_pkg::in_item_t   in_data_i,
  // output transactions
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output mgi_pkg::out_item_t       out_data_o,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  localparam int unsigned AddrW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned W     = mgi_pkg::WordW;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_ADD   = 4'd3;
  localparam logic [3:0] S_EMIT  = 4'd4;
  localparam logic [3:0] S_WB    = 4'd5;
  localparam logic [3:0] S_RMUL0 = 4'd6;
  localparam logic [3:0] S_RMUL1 = 4'd7;
  localparam logic [3:0] S_RWR   = 4'd8;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [6:0]   entries_q;
  logic [W-1:0] boundary_q;
  logic [15:0]  restitution_q;
  logic [2:0]   axis_mode_q;
  logic         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q     <= mgi_pkg::EntriesReset;
      boundary_q    <= '0;
      restitution_q <= mgi_pkg::RestitutionReset;
      axis_mode_q   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        mgi_pkg::RegEntries:     entries_q     <= pwdata[6:0];
        mgi_pkg::RegBoundary:    boundary_q    <= pwdata;
        mgi_pkg::RegRestitution: restitution_q <= pwdata[15:0];
        mgi_pkg::RegAxisMode:    axis_mode_q   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // register readback, signed fields sign-extended
  always_comb begin
    unique case (paddr[3:2])
      mgi_pkg::RegEntries:     prdata = {25'd0, entries_q};
      mgi_pkg::RegBoundary:    prdata = boundary_q;
      mgi_pkg::RegRestitution: prdata = {{16{restitution_q[15]}}, restitution_q};
      mgi_pkg::RegAxisMode:    prdata = {29'd0, axis_mode_q};
      default:                 prdata = '0;
    endcase
  end

  // active entry count, saturated to the table depth
  logic [CntW-1:0] n_w;
  assign n_w = (32'(entries_q) > 32'(MAX_ENTRIES)) ? CntW'(MAX_ENTRIES)
                                                   : CntW'(entries_q);

  logic check_en;
  logic axis_x;
  logic bounce;
  assign check_en = |axis_mode_q[1:0];
  assign axis_x   = axis_mode_q[0];
  assign bounce   = axis_mode_q[2];

  // ---------------------------------------------------------------------
  // sequencer registers
  // ---------------------------------------------------------------------
  logic [3:0]        state_q, state_d;
  logic [CntW-1:0]   idx_q, idx_d;
  mgi_pkg::in_item_t in_q, in_d;
  logic [W-1:0]      scale0_q, scale0_d;
  logic [W-1:0]      scale1_q, scale1_d;
  logic [W-1:0]      lo_q, lo_d;
  logic [2*W-1:0]    np_q, np_d;     // integrated position {y, x}
  logic [2*W-1:0]    nv_q, nv_d;     // updated velocity {y, x}
  logic              cross_q, cross_d;

  // output register
  logic               out_valid_q, out_valid_d;
  mgi_pkg::out_item_t out_q, out_d;
  logic               out_free;

  // ram ports
  logic [AddrW-1:0] raddr, waddr;
  logic             rd_en;
  logic             pos_we, vel_we, acc_we;
  logic [2*W-1:0]   pos_wdata, vel_wdata, acc_wdata;
  logic [2*W-1:0]   pos_rdata, vel_rdata, acc_rdata;

  // shared multiplier
  logic [W-1:0] mul_a, mul_b, mul_p;

  // check datapath
  logic [W-1:0] p_ax, v_ax, diff_now, diff_next, v_new;
  logic         le0, gt0, ge0, lt0, cross_w;
  logic         is_last;
  logic         load_ok;
  logic [W-1:0] ramp_lo;

  assign raddr    = idx_q[AddrW-1:0];
  assign out_free = !out_valid_q || out_ready_i;
  assign is_last  = (CntW'(idx_q + 1'b1) == n_w);
  assign load_ok  = (32'(in_q.entry_index) < 32'(MAX_ENTRIES));

  // side test on the selected axis, wrapped 32-bit differences
  assign p_ax      = axis_x ? np_q[W-1:0] : np_q[2*W-1:W];
  assign v_ax      = axis_x ? nv_q[W-1:0] : nv_q[2*W-1:W];
  assign diff_now  = p_ax - boundary_q;
  assign diff_next = p_ax + v_ax - boundary_q;
  assign le0       = diff_now[W-1] || (diff_now == '0);
  assign ge0       = !diff_now[W-1];
  assign gt0       = !diff_next[W-1] && (diff_next != '0);
  assign lt0       = diff_next[W-1];
  assign cross_w   = check_en && ((le0 && gt0) || (ge0 && lt0));

  // bounce velocity from the product registered during emit
  assign v_new   = bounce ? mgi_pkg::asr8(W'(0) - mul_p) : '0;
  assign ramp_lo = mgi_pkg::asr8(mul_p);

  // multiplier operand select: ramp x, ramp y, or restitution * v
  always_comb begin
    unique case (state_q)
      S_RMUL0: begin
        mul_a = in_q.first_value;
        mul_b = scale0_q;
      end
      S_RMUL1: begin
        mul_a = in_q.second_value;
        mul_b = scale1_q;
      end
      default: begin
        mul_a = {{(W-16){restitution_q[15]}}, restitution_q};
        mul_b = v_ax;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    in_d        = in_q;
    scale0_d    = scale0_q;
    scale1_d    = scale1_q;
    lo_d        = lo_q;
    np_d        = np_q;
    nv_d        = nv_q;
    cross_d     = cross_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    rd_en       = 1'b0;
    pos_we      = 1'b0;
    vel_we      = 1'b0;
    acc_we      = 1'b0;
    waddr       = idx_q[AddrW-1:0];
    pos_wdata   = np_q;
    vel_wdata   = nv_q;
    acc_wdata   = '0;
    in_ready_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          in_d     = in_data_i;
          idx_d    = '0;
          scale0_d = mgi_pkg::ScaleOne;
          scale1_d = mgi_pkg::ScaleOne;
          unique case (in_data_i.opcode)
            mgi_pkg::OpTick:    state_d = (n_w == '0) ? S_IDLE : S_RD;
            mgi_pkg::OpLoad:    state_d = S_LOAD;
            mgi_pkg::OpRampAcc,
            mgi_pkg::OpRampVel: state_d = (n_w == '0) ? S_IDLE : S_RMUL0;
            default:            state_d = S_IDLE;
          endcase
        end
      end

      // one entry: new position, motion cleared
      S_LOAD: begin
        waddr     = AddrW'(in_q.entry_index);
        pos_we    = load_ok;
        vel_we    = load_ok;
        acc_we    = load_ok;
        pos_wdata = {in_q.second_value, in_q.first_value};
        vel_wdata = '0;
        acc_wdata = '0;
        state_d   = S_IDLE;
      end

      // tick: fetch the entry from all three stores
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_ADD;
      end

      S_ADD: begin
        np_d[W-1:0]   = pos_rdata[W-1:0]   + vel_rdata[W-1:0];
        np_d[2*W-1:W] = pos_rdata[2*W-1:W] + vel_rdata[2*W-1:W];
        nv_d[W-1:0]   = vel_rdata[W-1:0]   + acc_rdata[W-1:0];
        nv_d[2*W-1:W] = vel_rdata[2*W-1:W] + acc_rdata[2*W-1:W];
        state_d       = S_EMIT;
      end

      // report the position once the output register is free
      S_EMIT: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.out_index = 6'(idx_q);
          out_d.pos_x     = np_q[W-1:0];
          out_d.pos_y     = np_q[2*W-1:W];
          out_d.last      = is_last;
          cross_d         = cross_w;
          state_d         = S_WB;
        end
      end

      // write back with the boundary snap applied
      S_WB: begin
        pos_we = 1'b1;
        vel_we = 1'b1;
        if (cross_q) begin
          if (axis_x) begin
            pos_wdata[W-1:0] = boundary_q;
            vel_wdata[W-1:0] = v_new;
          end else begin
            pos_wdata[2*W-1:W] = boundary_q;
            vel_wdata[2*W-1:W] = v_new;
          end
        end
        idx_d   = CntW'(idx_q + 1'b1);
        state_d = is_last ? S_IDLE : S_RD;
      end

      // ramp: x product, then y product, then write
      S_RMUL0: begin
        state_d = S_RMUL1;
      end

      S_RMUL1: begin
        lo_d    = ramp_lo;
        state_d = S_RWR;
      end

      S_RWR: begin
        acc_wdata = {ramp_lo, lo_q};
        vel_wdata = {ramp_lo, lo_q};
        acc_we    = (in_q.opcode == mgi_pkg::OpRampAcc);
        vel_we    = (in_q.opcode == mgi_pkg::OpRampVel);
        scale0_d  = scale0_q + in_q.first_step;
        scale1_d  = scale1_q + in_q.second_step;
        idx_d     = CntW'(idx_q + 1'b1);
        state_d   = is_last ? S_IDLE : S_RMUL0;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      cross_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      cross_q     <= cross_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    in_q     <= in_d;
    scale0_q <= scale0_d;
    scale1_q <= scale1_d;
    lo_q     <= lo_d;
    np_q     <= np_d;
    nv_q     <= nv_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // stores and the shared multiplier
  // ---------------------------------------------------------------------
  mgi_ram #(
    .Width (2 * W),
    .Depth (MAX_ENTRIES)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (waddr),
    .wdata_i (pos_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (pos_rdata)
  );

  mgi_ram #(
    .Width (2 * W),
    .Depth (MAX_ENTRIES)
  ) u_vel_ram (
    .clk_i   (clk_i),
    .we_i    (vel_we),
    .waddr_i (waddr),
    .wdata_i (vel_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (vel_rdata)
  );

  mgi_ram #(
    .Width (2 * W),
    .Depth (MAX_ENTRIES)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (waddr),
    .wdata_i (acc_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (acc_rdata)
  );

  mgi_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p)
  );

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // no store is touched while waiting for a transaction
  `MGI_ASSERT_NEVER(a_idle_no_write, clk_i, rst_ni, (state_q == S_IDLE) && (pos_we || vel_we || acc_we))
  // a freshly raised result always comes from the emit step
  `MGI_ASSERT(a_out_from_emit, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_EMIT))
  // emit with a free output register goes straight to write back
  `MGI_ASSERT(a_emit_to_wb, clk_i, rst_ni, (state_q == S_EMIT) && out_free |=> (state_q == S_WB))
  // ramp write only follows the second product
  `MGI_ASSERT(a_rwr_order, clk_i, rst_ni, (state_q == S_RWR) |-> $past(state_q == S_RMUL1))

endmodule

`default_nettype wire

// ===== rtl/core/mgi_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module mgi_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = mgi_pkg::MaxEntriesDefault,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/mgi_mul.sv =====
// shared 32x32 multiplier, low word of the product, registered output
`default_nettype none

module mgi_mul (
  input  wire logic                          clk_i,
  input  wire logic [mgi_pkg::WordW-1:0]     a_i,
  input  wire logic [mgi_pkg::WordW-1:0]     b_i,
  output logic      [mgi_pkg::WordW-1:0]     prod_o
);

  logic [mgi_pkg::WordW-1:0] prod_q;

  // low word is the same for signed and unsigned operands
  always_ff @(posedge clk_i) begin
    prod_q <= mgi_pkg::WordW'(a_i * b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire
